### rtl/kdt_pkg.sv
// Shared types, constants and character helpers for the keypad digit trie counter.
package kdt_pkg;

  localparam int ENTRIES_DEF = 4096;
  localparam int KEY_LEN_DEF = 6;
  localparam int FANOUT      = 10;
  localparam int CHAR_FIELDS = 6;
  localparam int COUNT_W     = 16;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOKEY   = 2'd1,
    ST_BADCHAR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_HITINC,
    S_RDHIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] entry_index;
    logic [2:0]  length;
    logic [6:0]  char_0;
    logic [6:0]  char_1;
    logic [6:0]  char_2;
    logic [6:0]  char_3;
    logic [6:0]  char_4;
    logic [6:0]  char_5;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  function automatic logic [3:0] keypad_digit(input logic [6:0] c);
    logic [3:0] d;
    d = 4'd0;
    case (c)
      "a", "b", "c":      d = 4'd2;
      "d", "e", "f":      d = 4'd3;
      "g", "h", "i":      d = 4'd4;
      "j", "k", "l":      d = 4'd5;
      "m", "n", "o":      d = 4'd6;
      "p", "q", "r", "s": d = 4'd7;
      "t", "u", "v":      d = 4'd8;
      "w", "x", "y", "z": d = 4'd9;
      default:            d = 4'd0;
    endcase
    return d;
  endfunction

  function automatic logic is_digit(input logic [6:0] c);
    return (c >= 7'h30) && (c <= 7'h39);
  endfunction

endpackage

### rtl/kdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/kdt_ctrl.sv
// Sequencer: trie walk, node allocation, counter update and result register.
module kdt_ctrl #(
  parameter int ENTRIES  = 4096,
  parameter int KEY_LEN  = 6,
  localparam int NODES   = 1 + ENTRIES * KEY_LEN,
  localparam int LINK_W  = $clog2(NODES),
  localparam int CNT_W   = $clog2(NODES + 1),
  localparam int ENT_W   = $clog2(ENTRIES + 1),
  localparam int HIT_AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int ROW_W   = ENT_W + kdt_pkg::FANOUT * LINK_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  kdt_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output kdt_pkg::out_item_t         out_item,
  output logic                       node_we,
  output logic [LINK_W-1:0]          node_waddr,
  output logic [ROW_W-1:0]           node_wdata,
  output logic [LINK_W-1:0]          node_raddr,
  input  logic [ROW_W-1:0]           node_rdata,
  output logic                       hit_we,
  output logic [HIT_AW-1:0]          hit_waddr,
  output logic [kdt_pkg::COUNT_W-1:0] hit_wdata,
  output logic [HIT_AW-1:0]          hit_raddr,
  input  logic [kdt_pkg::COUNT_W-1:0] hit_rdata
);
  import kdt_pkg::*;

  localparam int CAP = (KEY_LEN < CHAR_FIELDS) ? KEY_LEN : CHAR_FIELDS;

  state_t                             state_r, state_nxt;
  op_t                                op_r, op_nxt;
  logic [11:0]                        idx_r, idx_nxt;
  logic [2:0]                         n_r, n_nxt;
  logic [CHAR_FIELDS-1:0][3:0]        dig_r, dig_nxt;
  logic [LINK_W-1:0]                  node_r, node_nxt;
  logic [2:0]                         lvl_r, lvl_nxt;
  logic [CNT_W-1:0]                   used_r, used_nxt;
  logic [HIT_AW-1:0]                  clr_r, clr_nxt;
  logic                               reply_r, reply_nxt;
  logic [HIT_AW-1:0]                  haddr_r, haddr_nxt;
  status_t                            status_r, status_nxt;
  logic [COUNT_W-1:0]                 count_r, count_nxt;
  logic                               out_valid_r, out_valid_nxt;
  out_item_t                          out_item_r, out_item_nxt;

  logic [FANOUT-1:0][LINK_W-1:0]      links;
  logic [ENT_W-1:0]                   row_ent;
  logic [3:0]                         cur_dig;
  logic [LINK_W-1:0]                  child;
  logic                               at_end, fits, entry_ok, idx_ok, clr_last;
  logic [CNT_W:0]                     missing;
  logic [6:0]                         chars [CHAR_FIELDS];
  logic [2:0]                         in_n;
  logic [CHAR_FIELDS-1:0][3:0]        in_dig;
  logic                               in_bad;
  logic [ENT_W-1:0]                   new_ent;

  assign {row_ent, links} = node_rdata;
  assign cur_dig  = dig_r[lvl_r];
  assign child    = links[cur_dig];
  assign at_end   = (lvl_r == n_r);
  assign missing  = (CNT_W + 1)'(n_r - lvl_r);
  assign fits     = ({1'b0, used_r} + missing) <= (CNT_W + 1)'(NODES);
  assign entry_ok = (row_ent != '0) && (row_ent <= ENT_W'(ENTRIES));
  assign idx_ok   = {2'b00, in_item.entry_index} < 14'(ENTRIES);
  assign clr_last = (clr_r == HIT_AW'(ENTRIES - 1));
  assign new_ent  = ENT_W'({2'b00, idx_r} + 14'd1);

  assign chars[0] = in_item.char_0;
  assign chars[1] = in_item.char_1;
  assign chars[2] = in_item.char_2;
  assign chars[3] = in_item.char_3;
  assign chars[4] = in_item.char_4;
  assign chars[5] = in_item.char_5;

  always_comb begin
    in_n = in_item.length;
    if (in_n == 3'd0) begin
      in_n = 3'd1;
    end
    if (in_n > 3'(CAP)) begin
      in_n = 3'(CAP);
    end
    in_bad = 1'b0;
    for (int i = 0; i < CHAR_FIELDS; i++) begin
      if (in_item.operation == OP_INSERT) begin
        in_dig[i] = 4'(chars[i] - 7'h30);
        if ((3'(i) < in_n) && !is_digit(chars[i])) begin
          in_bad = 1'b1;
        end
      end else begin
        in_dig[i] = keypad_digit(chars[i]);
      end
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_last) begin
          state_nxt = reply_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_item.operation))
            OP_CLEAR:  state_nxt = S_CLEAR;
            OP_INSERT: state_nxt = (in_bad || !idx_ok) ? S_DONE : S_WALK;
            OP_QUERY:  state_nxt = S_WALK;
            OP_READ:   state_nxt = idx_ok ? S_RDHIT : S_DONE;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_WALK: begin
        if (at_end) begin
          state_nxt = (op_r == OP_QUERY && entry_ok) ? S_HITINC : S_DONE;
        end else if (child != '0) begin
          state_nxt = S_WALK;
        end else begin
          state_nxt = (op_r == OP_INSERT && fits) ? S_ALLOC : S_DONE;
        end
      end
      S_ALLOC: begin
        if (at_end) begin
          state_nxt = S_DONE;
        end
      end
      S_HITINC: state_nxt = S_DONE;
      S_RDHIT:  state_nxt = S_DONE;
      S_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    logic [FANOUT-1:0][LINK_W-1:0] wl;
    wl            = links;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    dig_nxt       = dig_r;
    node_nxt      = node_r;
    lvl_nxt       = lvl_r;
    used_nxt      = used_r;
    clr_nxt       = clr_r;
    reply_nxt     = reply_r;
    haddr_nxt     = haddr_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    node_we       = 1'b0;
    node_waddr    = node_r;
    node_wdata    = {row_ent, links};
    node_raddr    = child;
    hit_we        = 1'b0;
    hit_waddr     = haddr_r;
    hit_wdata     = '0;
    hit_raddr     = haddr_r;
    case (state_r)
      S_CLEAR: begin
        hit_we     = 1'b1;
        hit_waddr  = clr_r;
        clr_nxt    = clr_r + HIT_AW'(1);
        used_nxt   = CNT_W'(1);
        status_nxt = ST_OK;
        count_nxt  = '0;
        if (clr_r == '0) begin
          node_we    = 1'b1;
          node_waddr = '0;
          node_wdata = '0;
        end
      end
      S_IDLE: begin
        node_raddr = '0;
        hit_raddr  = HIT_AW'(in_item.entry_index);
        if (in_valid) begin
          op_nxt     = op_t'(in_item.operation);
          idx_nxt    = in_item.entry_index;
          n_nxt      = in_n;
          dig_nxt    = in_dig;
          node_nxt   = '0;
          lvl_nxt    = 3'd0;
          clr_nxt    = '0;
          reply_nxt  = 1'b1;
          count_nxt  = '0;
          status_nxt = (in_item.operation == OP_INSERT && in_bad) ? ST_BADCHAR : ST_OK;
        end
      end
      S_WALK: begin
        if (at_end) begin
          if (op_r == OP_INSERT) begin
            node_we    = 1'b1;
            node_wdata = {new_ent, links};
          end else if (entry_ok) begin
            hit_raddr = HIT_AW'(row_ent - ENT_W'(1));
            haddr_nxt = HIT_AW'(row_ent - ENT_W'(1));
          end else begin
            status_nxt = ST_NOKEY;
          end
        end else if (child != '0) begin
          node_nxt = child;
          lvl_nxt  = lvl_r + 3'd1;
        end else if (op_r == OP_QUERY) begin
          status_nxt = ST_NOKEY;
        end else if (fits) begin
          wl[cur_dig] = LINK_W'(used_r);
          node_we     = 1'b1;
          node_wdata  = {row_ent, wl};
          lvl_nxt     = lvl_r + 3'd1;
        end
      end
      S_ALLOC: begin
        wl         = '0;
        node_we    = 1'b1;
        node_waddr = LINK_W'(used_r);
        used_nxt   = used_r + CNT_W'(1);
        lvl_nxt    = lvl_r + 3'd1;
        if (at_end) begin
          node_wdata = {new_ent, wl};
        end else begin
          wl[cur_dig] = LINK_W'(used_r + CNT_W'(1));
          node_wdata  = {ENT_W'(0), wl};
        end
      end
      S_HITINC: begin
        hit_we    = 1'b1;
        hit_wdata = (hit_rdata == '1) ? hit_rdata : hit_rdata + COUNT_W'(1);
      end
      S_RDHIT: begin
        count_nxt = hit_rdata;
      end
      S_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt       = 1'b1;
          out_item_nxt.status = status_r;
          out_item_nxt.count  = count_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      reply_r     <= 1'b0;
      used_r      <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      reply_r     <= reply_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    dig_r      <= dig_nxt;
    node_r     <= node_nxt;
    lvl_r      <= lvl_nxt;
    haddr_r    <= haddr_nxt;
    status_r   <= status_nxt;
    count_r    <= count_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### rtl/keypad_digit_trie_match_counter_top.sv
// Top level of the keypad digit trie match counter: node and counter memories plus sequencer.
// Keys of 1 to KEY_LEN digits, at most six, live in a trie whose nodes are rows of one
// node memory (ten child links and an entry tag per row); hit counters live in a second
// memory of ENTRIES words. One item is worked at a time, bounded by the node memory read
// port: an insert or query reads one row per trie level, stopping early when a query misses;
// rows of newly allocated nodes are written one per level in place of the reads the walk
// would have made, and a matching query also does a counter read-modify-write. A read
// fetches one counter word, and an insert with a non-digit goes straight to its result.
// Clear, and likewise reset, sweeps the counter memory one word a cycle. A finished result
// sits in an output register, so the next item is taken while it waits; a further result
// holds the sequencer, and with it the input, until then.
module keypad_digit_trie_match_counter_top #(
  parameter int ENTRIES = kdt_pkg::ENTRIES_DEF,
  parameter int KEY_LEN = kdt_pkg::KEY_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kdt_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output kdt_pkg::out_item_t out_item
);
  import kdt_pkg::*;

  localparam int NODES  = 1 + ENTRIES * KEY_LEN;
  localparam int LINK_W = $clog2(NODES);
  localparam int ENT_W  = $clog2(ENTRIES + 1);
  localparam int HIT_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ROW_W  = ENT_W + FANOUT * LINK_W;

  logic               node_we;
  logic [LINK_W-1:0]  node_waddr, node_raddr;
  logic [ROW_W-1:0]   node_wdata, node_rdata;
  logic               hit_we;
  logic [HIT_AW-1:0]  hit_waddr, hit_raddr;
  logic [COUNT_W-1:0] hit_wdata, hit_rdata;

  kdt_ram #(.WIDTH(ROW_W), .DEPTH(NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  kdt_ram #(.WIDTH(COUNT_W), .DEPTH(ENTRIES)) u_hit_ram (
    .clk   (clk),
    .we    (hit_we),
    .waddr (hit_waddr),
    .wdata (hit_wdata),
    .raddr (hit_raddr),
    .rdata (hit_rdata)
  );

  kdt_ctrl #(.ENTRIES(ENTRIES), .KEY_LEN(KEY_LEN)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .node_we    (node_we),
    .node_waddr (node_waddr),
    .node_wdata (node_wdata),
    .node_raddr (node_raddr),
    .node_rdata (node_rdata),
    .hit_we     (hit_we),
    .hit_waddr  (hit_waddr),
    .hit_wdata  (hit_wdata),
    .hit_raddr  (hit_raddr),
    .hit_rdata  (hit_rdata)
  );

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while an item is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == ST_OK || out_item.status == ST_NOKEY ||
                   out_item.status == ST_BADCHAR))
    else $error("illegal status code");

  a_count_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.count != '0 |-> out_item.status == ST_OK)
    else $error("nonzero count with failing status");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the keypad digit trie match counter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kdt_pkg::*;

  localparam int N_ENTRIES = 4096;
  localparam int N_NODES = 1 + N_ENTRIES * 6;
  localparam int N_RANDOM = 640;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_item_t out_item;

  keypad_digit_trie_match_counter_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // trie shadow
  int unsigned links[N_NODES][10];
  int unsigned tags[N_NODES];
  int unsigned used_nodes;
  logic [15:0] hits[N_ENTRIES];
  out_item_t pending_q[$];
  int errors = 0;
  int n_results = 0;
  int n_matches = 0;
  bit quiet = 1'b0;
  int hold_off = 0;

  function automatic void wipe_trie();
    used_nodes = 1;
    for (int k = 0; k < 10; k++) links[0][k] = 0;
    tags[0] = 0;
    for (int k = 0; k < N_ENTRIES; k++) hits[k] = '0;
  endfunction

  function automatic int unsigned letter_key(logic [6:0] c);
    if (c >= "a" && c <= "z") begin
      if (c <= "o") return (c - "a") / 3 + 2;
      if (c <= "s") return 7;
      if (c <= "v") return 8;
      return 9;
    end
    return 0;
  endfunction

  function automatic out_item_t trie_step(in_item_t it);
    out_item_t r;
    int unsigned n, p, miss;
    int unsigned dg[6];
    logic [6:0] ch[6];
    bit bad, on_path;
    r = '0;
    ch = '{it.char_0, it.char_1, it.char_2, it.char_3, it.char_4, it.char_5};
    n = (it.length == 0) ? 1 : ((it.length > 6) ? 6 : it.length);
    case (op_t'(it.operation))
      OP_CLEAR: wipe_trie();
      OP_INSERT: begin
        bad = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (ch[i] < "0" || ch[i] > "9") bad = 1'b1;
          else dg[i] = ch[i] - "0";
        end
        if (bad) r.status = ST_BADCHAR;
        else if (it.entry_index < N_ENTRIES) begin
          p = 0; miss = 0; on_path = 1'b1;
          for (int i = 0; i < n; i++) begin
            if (on_path && links[p][dg[i]] != 0) p = links[p][dg[i]];
            else begin on_path = 1'b0; miss++; end
          end
          if (miss <= N_NODES - used_nodes) begin
            p = 0;
            for (int i = 0; i < n; i++) begin
              if (links[p][dg[i]] == 0) begin
                for (int k = 0; k < 10; k++) links[used_nodes][k] = 0;
                tags[used_nodes] = 0;
                links[p][dg[i]] = used_nodes;
                used_nodes++;
              end
              p = links[p][dg[i]];
            end
            tags[p] = it.entry_index + 1;
          end
        end
      end
      OP_QUERY: begin
        p = 0;
        r.status = ST_OK;
        for (int i = 0; i < n; i++) begin
          if (r.status == ST_OK) begin
            p = links[p][letter_key(ch[i])];
            if (p == 0) r.status = ST_NOKEY;
          end
        end
        if (r.status == ST_OK) begin
          if (tags[p] == 0 || tags[p] > N_ENTRIES) r.status = ST_NOKEY;
          else if (hits[tags[p] - 1] != 16'hFFFF) hits[tags[p] - 1]++;
        end
      end
      default: if (it.entry_index < N_ENTRIES) r.count = hits[it.entry_index];
    endcase
    return r;
  endfunction

  task automatic send_item(in_item_t it);
    @(negedge clk);
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(trie_step(it));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_gap();
    if (!quiet && $urandom_range(99) < 6) begin
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  function automatic in_item_t mk(op_t op, int idx, int len, string s);
    in_item_t it;
    logic [6:0] c[6];
    for (int i = 0; i < 6; i++) c[i] = (i < s.len()) ? 7'(s[i]) : 7'h00;
    it.operation = op; it.entry_index = 12'(idx); it.length = 3'(len);
    it.char_0 = c[0]; it.char_1 = c[1]; it.char_2 = c[2];
    it.char_3 = c[3]; it.char_4 = c[4]; it.char_5 = c[5];
    return it;
  endfunction

  function automatic in_item_t rnd_word(op_t op, bit digits, int idx);
    in_item_t it;
    logic [6:0] c[6];
    int len;
    len = $urandom_range(6, 1);
    for (int i = 0; i < 6; i++) begin
      // short keys and small alphabets to get hits
      if (digits) c[i] = 7'("2" + $urandom_range(3));
      else c[i] = 7'("a" + 3 * $urandom_range(3));
    end
    if ($urandom_range(19) == 0) c[$urandom_range(5)] = 7'($urandom_range(127));
    if ($urandom_range(9) == 0) len = $urandom_range(7);
    if (len > 3 && $urandom_range(1)) len = $urandom_range(3, 1);
    it = mk(op, idx, len, "");
    it.char_0 = c[0]; it.char_1 = c[1]; it.char_2 = c[2];
    it.char_3 = c[3]; it.char_4 = c[4]; it.char_5 = c[5];
    return it;
  endfunction

  typedef struct {
    in_item_t it;
    bit fixed;
    out_item_t want;
  } dir_row_t;

  // receiver and checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $realtime, out_item);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (want.status == ST_OK && out_item.status == ST_OK) n_matches++;
        if (out_item.status !== want.status || out_item.count !== want.count) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, want, out_item);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (!rst_n) out_stall <= 1'b1;
    else out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 6);
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    in_item_t it;
    int idx;
    int n_rand;
    wipe_trie();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    rows = '{
      '{mk(OP_READ, 0, 1, ""), 1, '{ST_OK, 16'd0}},
      '{mk(OP_QUERY, 0, 1, "a"), 1, '{ST_NOKEY, 16'd0}},
      '{mk(OP_INSERT, 0, 1, "2"), 1, '{ST_OK, 16'd0}},
      '{mk(OP_QUERY, 0, 1, "c"), 1, '{ST_OK, 16'd0}},
      '{mk(OP_READ, 0, 1, ""), 1, '{ST_OK, 16'd1}},
      '{mk(OP_INSERT, 4095, 6, "999999"), 0, '{ST_OK, 16'd0}},
      '{mk(OP_QUERY, 0, 6, "wxyzwz"), 0, '{ST_OK, 16'd0}},
      '{mk(OP_READ, 4095, 7, ""), 0, '{ST_OK, 16'd0}},
      '{mk(OP_INSERT, 7, 2, "2a"), 1, '{ST_BADCHAR, 16'd0}},
      '{mk(OP_INSERT, 7, 0, "/"), 1, '{ST_BADCHAR, 16'd0}},
      '{mk(OP_INSERT, 8, 0, "0"), 0, '{ST_OK, 16'd0}},
      '{mk(OP_QUERY, 0, 0, "A"), 0, '{ST_OK, 16'd0}},
      '{mk(OP_QUERY, 0, 1, "\177"), 0, '{ST_OK, 16'd0}},
      '{mk(OP_INSERT, 9, 7, "23456:"), 1, '{ST_BADCHAR, 16'd0}},
      '{mk(OP_INSERT, 9, 7, "234567"), 0, '{ST_OK, 16'd0}},
      '{mk(OP_QUERY, 0, 7, "adgjmp"), 0, '{ST_OK, 16'd0}},
      '{mk(OP_INSERT, 10, 6, "234567"), 0, '{ST_OK, 16'd0}},
      '{mk(OP_QUERY, 0, 6, "behkoq"), 0, '{ST_OK, 16'd0}},
      '{mk(OP_READ, 10, 1, ""), 0, '{ST_OK, 16'd0}},
      '{mk(OP_READ, 9, 1, ""), 0, '{ST_OK, 16'd0}},
      '{mk(OP_QUERY, 0, 3, "adg"), 0, '{ST_OK, 16'd0}},
      '{mk(OP_INSERT, 11, 3, "8/9"), 0, '{ST_OK, 16'd0}},
      '{mk(OP_CLEAR, 4095, 7, "zzzzzz"), 1, '{ST_OK, 16'd0}},
      '{mk(OP_READ, 0, 1, ""), 1, '{ST_OK, 16'd0}},
      '{mk(OP_QUERY, 0, 1, "c"), 1, '{ST_NOKEY, 16'd0}}
    };
    foreach (rows[i]) begin
      if (rows[i].fixed) begin
        it = rows[i].it;
        if (trie_step(it) != rows[i].want) begin
          $display("%0t: table row %0d expected %p", $realtime, i, rows[i].want);
          errors++;
        end
        void'(pending_q.size());
      end
    end
    // replay table against the DUT from a clean state
    wipe_trie();
    foreach (rows[i]) begin
      send_gap();
      send_item(rows[i].it);
    end
    drain();

    // repeated hits on one counter, no idling
    send_item(mk(OP_INSERT, 1, 1, "5"));
    quiet = 1'b1;
    for (int k = 0; k < 40; k++) send_item(mk(OP_QUERY, 0, 1, "j"));
    quiet = 1'b0;
    send_item(mk(OP_READ, 1, 1, ""));
    drain();

    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      if (n_rand == 200) hold_off <= 300;
      if (n_rand == 400) begin
        drain();
        repeat (40) @(negedge clk);
      end
      if (n_rand == 500) send_item(mk(OP_CLEAR, $urandom_range(4095), 1, ""));
      idx = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(15);
      case ($urandom_range(9))
        0, 1, 2: it = rnd_word(OP_INSERT, 1'b1, idx);
        3, 4, 5, 6: it = rnd_word(OP_QUERY, 1'b0, idx);
        7, 8: it = rnd_word(OP_READ, 1'b0, idx);
        default: begin
          it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
          if (it.operation == OP_CLEAR) it.operation = OP_READ;
        end
      endcase
      send_gap();
      send_item(it);
      n_rand++;
    end
    drain();
    repeat (20) @(negedge clk);
    $display("covered %0d results, %0d ok statuses: directed table, repeated hits,",
             n_results, n_matches);
    $display("clear, bad keys, a long output hold-off and a full drain");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### files.f
rtl/kdt_pkg.sv
rtl/kdt_ram.sv
rtl/kdt_ctrl.sv
rtl/keypad_digit_trie_match_counter_top.sv
dv/tb_top.sv
